[hw/rtl/fpq_pkg.sv]
// Shared types and constants for the four-level priority queue with aging.
// No dependencies.
`timescale 1ns / 1ps
package fpq_pkg;
  localparam int NUM_LEVELS = 4;
  localparam int WAIT_BITS  = 8;
  localparam logic [WAIT_BITS-1:0] WAIT_MAX = 8'hFF;
  localparam logic [7:0] AGE_STEP_RST   = 8'd5;
  localparam logic [7:0] AGE_THRESH_RST = 8'd10;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_AGE  = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic {
    CFG_AGE_STEP   = 1'b0,
    CFG_AGE_THRESH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] served_id;
    logic [1:0]  served_level;
    logic [6:0]  promoted_count;
  } result_t;
endpackage

[hw/rtl/four_level_priority_queue_with_aging_unit.sv]
// Top level: configuration registers, request front end and queue engine.
// Depends on fpq_pkg, fpq_front, fpq_engine.
//
// Usage: requests enter on in_* (tdata: kind, entry_id, level from bit 0).
// Each request yields exactly one result on out_* (tdata: status,
// served_id, served_level, promoted_count from bit 0).
// The engine registers the result of an enqueue, no-op or empty dequeue in
// S_IDLE, of any other dequeue in S_DEQ after the memory read, and of an
// aging tick in S_OUT after walking level 3 then level 2 in the single
// memory (each entry read in S_ARD, written back or promoted in S_AWR).
// S_WAIT follows each request before the next one is taken.
// A two-entry request queue decouples the input from the engine; the engine
// holds its result until out_tready and takes no new request meanwhile, so
// in_tready drops once two more requests are queued.
// Reset empties all levels and loads age_step 5, age_threshold 10.
// Configuration (cfg_index 0 step, 1 threshold) is to be written by the user
// only when idle; the block itself does not enforce it.
`timescale 1ns / 1ps
module four_level_priority_queue_with_aging_unit #(
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // kind[1:0], entry_id[17:2], level[19:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status, served_id, served_level, promoted_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import fpq_pkg::*;
  logic [7:0] step_r, thr_r;
  logic rv, rr;
  logic [1:0] rk, rl;
  logic [ID_BITS-1:0] rid, iid;
  result_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= AGE_STEP_RST; thr_r <= AGE_THRESH_RST;
    end else if (cfg_valid) begin
      if (cfg_idx_t'(cfg_index) == CFG_AGE_STEP) step_r <= cfg_data;
      else thr_r <= cfg_data;
    end
  end

  assign iid = ID_BITS'({{(ID_BITS > 16 ? ID_BITS-16 : 1){1'b0}}, in_tdata[17:2]});

  fpq_front #(.ID_BITS(ID_BITS)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_kind(in_tdata[1:0]), .in_id(iid), .in_level(in_tdata[19:18]),
    .req_valid(rv), .req_ready(rr), .req_kind(rk), .req_id(rid), .req_level(rl));

  fpq_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_eng (
    .clk, .rst_n, .age_step(step_r), .age_thresh(thr_r),
    .req_valid(rv), .req_ready(rr), .req_kind(rk), .req_id(rid), .req_level(rl),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res));

  assign out_tdata = {5'd0, res.promoted_count, res.served_level, res.served_id, res.status};

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.status != ST_RSVD) else $error("bad status");
  a_emp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.status == ST_EMPTY) |-> res.served_id == '0) else $error("empty id");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
endmodule

[hw/rtl/fpq_front.sv]
// Front end: accepts requests and holds them in a two-entry queue for the engine.
// Depends on fpq_pkg.
`timescale 1ns / 1ps
module fpq_front #(
  parameter int ID_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [ID_BITS-1:0] in_id,
  input  logic [1:0]         in_level,
  output logic               req_valid,
  input  logic               req_ready,
  output logic [1:0]         req_kind,
  output logic [ID_BITS-1:0] req_id,
  output logic [1:0]         req_level
);
  import fpq_pkg::*;
  localparam int W = 4 + ID_BITS;
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign req_valid = (cnt_r != 2'd0);
  assign push = in_valid && in_ready;
  assign pop  = req_valid && req_ready;
  assign {req_kind, req_level, req_id} = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= {in_kind, in_level, in_id};
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[hw/rtl/fpq_engine.sv]
// Back end: level storage in one memory, pointer moves for enqueue and dequeue,
// and a sequencer that walks levels 3 and 2 on an aging tick. Depends on fpq_pkg.
`timescale 1ns / 1ps
module fpq_engine #(
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         age_step,
  input  logic [7:0]         age_thresh,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         req_kind,
  input  logic [ID_BITS-1:0] req_id,
  input  logic [1:0]         req_level,
  output logic               res_valid,
  input  logic               res_ready,
  output fpq_pkg::result_t   res
);
  import fpq_pkg::*;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = 2 + PW;
  localparam int EW = ID_BITS + WAIT_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEQ   = 7'b0000010,
    S_ARD   = 7'b0000100,
    S_AWR   = 7'b0001000,
    S_ANEXT = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [EW-1:0] mem [NUM_LEVELS << PW];
  logic [EW-1:0] rd_r;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [EW-1:0] wd;
  logic [PW-1:0] head_r [NUM_LEVELS];
  logic [CW-1:0] cnt_r  [NUM_LEVELS];
  logic [1:0]    src_r;
  logic [CW-1:0] idx_r, n_r, keep_r;
  logic [6:0]    prom_r;
  logic [1:0]    dlvl_r;
  result_t       res_r;
  logic          res_v_r;

  function automatic logic [PW-1:0] wrap(input logic [PW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = {{(CW+1-PW){1'b0}}, h} + {1'b0, o};
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return s[PW-1:0];
  endfunction

  // dequeue level: lowest-numbered non-empty level
  logic [1:0] sel_l;
  logic       any;
  always_comb begin
    sel_l = 2'd0; any = 1'b0;
    for (int l = NUM_LEVELS-1; l >= 0; l--)
      if (cnt_r[l] != '0) begin sel_l = 2'(l); any = 1'b1; end
  end

  // result of a request taken in idle: full level or all empty
  result_t res_idle;
  always_comb begin
    res_idle = '0;
    if (kind_t'(req_kind) == KIND_ENQ && !(cnt_r[req_level] < CW'(QUEUE_DEPTH)))
      res_idle.status = ST_FULL;
    else if (kind_t'(req_kind) == KIND_DEQ && !any)
      res_idle.status = ST_EMPTY;
  end

  // aging datapath
  logic [8:0]           wsum;
  logic [WAIT_BITS-1:0] wsat;
  logic                 ripe, dst_room;
  logic [1:0]           dst;
  assign dst      = src_r - 2'd1;
  assign wsum     = {1'b0, rd_r[WAIT_BITS-1:0]} + {1'b0, age_step};
  assign wsat     = wsum[8] ? WAIT_MAX : wsum[7:0];
  assign dst_room = cnt_r[dst] < CW'(QUEUE_DEPTH);
  assign ripe     = (wsat >= age_thresh) && dst_room;

  assign req_ready = (state_r == S_IDLE) && !res_v_r;
  assign res_valid = res_v_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  always_comb begin
    we = 1'b0; wa = '0; wd = '0;
    ra = {src_r, wrap(head_r[src_r], idx_r)};
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (req_valid && req_ready) begin
        unique case (kind_t'(req_kind))
          KIND_ENQ: if (cnt_r[req_level] < CW'(QUEUE_DEPTH)) begin
            we = 1'b1;
            wa = {req_level, wrap(head_r[req_level], cnt_r[req_level])};
            wd = {req_id, {WAIT_BITS{1'b0}}};
          end
          KIND_DEQ: ra = {sel_l, head_r[sel_l]};
          default: ;
        endcase
        if (kind_t'(req_kind) == KIND_DEQ) state_nxt = S_DEQ;
        else if (kind_t'(req_kind) == KIND_AGE) state_nxt = S_ARD;
        else state_nxt = S_WAIT;
      end
      S_DEQ:  state_nxt = S_WAIT;
      S_ARD:  state_nxt = (idx_r < n_r) ? S_AWR : S_ANEXT;
      S_AWR: begin
        we = 1'b1;
        if (ripe) begin
          wa = {dst, wrap(head_r[dst], cnt_r[dst])};
          wd = {rd_r[EW-1:WAIT_BITS], {WAIT_BITS{1'b0}}};
        end else begin
          wa = {src_r, wrap(head_r[src_r], keep_r)};
          wd = {rd_r[EW-1:WAIT_BITS], wsat};
        end
        state_nxt = S_ARD;
      end
      S_ANEXT: state_nxt = (src_r == 2'd3) ? S_ARD : S_OUT;
      S_OUT:   state_nxt = S_WAIT;
      S_WAIT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; res_v_r <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_r[l] <= '0; cnt_r[l] <= '0;
      end
      src_r <= 2'd3; idx_r <= '0; n_r <= '0; keep_r <= '0; prom_r <= '0; dlvl_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (res_v_r && res_ready) res_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (req_valid && req_ready) begin
          res_r <= res_idle;
          unique case (kind_t'(req_kind))
            KIND_ENQ: begin
              res_v_r <= 1'b1;
              if (cnt_r[req_level] < CW'(QUEUE_DEPTH))
                cnt_r[req_level] <= cnt_r[req_level] + 1'b1;
            end
            KIND_DEQ: begin
              dlvl_r <= sel_l;
              if (any) begin
                cnt_r[sel_l]  <= cnt_r[sel_l] - 1'b1;
                head_r[sel_l] <= wrap(head_r[sel_l], CW'(1));
              end else begin
                res_v_r <= 1'b1;
              end
            end
            KIND_AGE: begin
              src_r <= 2'd3; idx_r <= '0; keep_r <= '0; prom_r <= '0;
              n_r <= cnt_r[3];
            end
            default: res_v_r <= 1'b1;
          endcase
        end
        S_DEQ: if (res_r.status == ST_DONE) begin
          res_r.served_id    <= 16'(rd_r[EW-1:WAIT_BITS]);
          res_r.served_level <= dlvl_r;
          res_v_r <= 1'b1;
        end
        S_AWR: begin
          idx_r <= idx_r + 1'b1;
          if (ripe) begin
            cnt_r[dst] <= cnt_r[dst] + 1'b1;
            prom_r <= prom_r + 7'd1;
          end else keep_r <= keep_r + 1'b1;
        end
        S_ARD: if (!(idx_r < n_r)) begin
          // compact: surviving entries sit at head..head+keep-1
          cnt_r[src_r] <= keep_r;
        end
        S_ANEXT: if (src_r == 2'd3) begin
          src_r <= 2'd2; idx_r <= '0; keep_r <= '0; n_r <= cnt_r[2];
        end
        S_OUT: begin
          res_r.promoted_count <= prom_r;
          res_v_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

[tb/four_level_priority_queue_with_aging_unit_test.sv]
// Testbench for the four-level priority queue with aging: directed and random requests,
// checked against a behavioral queue model. Depends on fpq_pkg and the unit top level.
`timescale 1ns / 1ps
module four_level_priority_queue_with_aging_unit_test;
  import fpq_pkg::*;

  localparam int DEPTH = 32;

  typedef struct {
    logic [15:0] id;
    int unsigned wait_cnt;
  } slot_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  four_level_priority_queue_with_aging_unit i_dut (.*);

  always #6 clk = ~clk;

  slot_t       levels [4][$];
  int unsigned step_val = 5;
  int unsigned thresh_val = 10;
  result_t     expected_results[$];
  int          mismatches = 0;
  bit          idle_on = 1'b1;
  int          hold_cycles = 0;
  bit          long_hold_go = 1'b0;
  bit          long_hold_done = 1'b0;

  // Move ripe entries from one level down to the next more urgent one.
  function automatic int unsigned promote_level(int src, int dst);
    slot_t       kept[$];
    slot_t       e;
    int unsigned w;
    int unsigned moved = 0;
    for (int i = 0; i < levels[src].size(); i++) begin
      e = levels[src][i];
      w = e.wait_cnt + step_val;
      if (w > 255) w = 255;
      if (w >= thresh_val && levels[dst].size() < DEPTH) begin
        e.wait_cnt = 0;
        levels[dst].push_back(e);
        moved++;
      end else begin
        e.wait_cnt = w;
        kept.push_back(e);
      end
    end
    levels[src] = kept;
    return moved;
  endfunction

  function automatic result_t serve_request(kind_t k, logic [15:0] id, logic [1:0] lvl);
    result_t r;
    slot_t   s;
    r = '0;
    case (k)
      KIND_ENQ: begin
        if (levels[lvl].size() >= DEPTH) r.status = ST_FULL;
        else begin
          s.id = id;
          s.wait_cnt = 0;
          levels[lvl].push_back(s);
        end
      end
      KIND_DEQ: begin
        r.status = ST_EMPTY;
        for (int l = 0; l < 4; l++) begin
          if (r.status == ST_EMPTY && levels[l].size() > 0) begin
            s = levels[l].pop_front();
            r.status = ST_DONE;
            r.served_id = s.id;
            r.served_level = l[1:0];
          end
        end
      end
      KIND_AGE: begin
        r.promoted_count = 7'(promote_level(3, 2));
        r.promoted_count += 7'(promote_level(2, 1));
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pending_total();
    return levels[0].size() + levels[1].size() + levels[2].size() + levels[3].size();
  endfunction

  task automatic send_request(kind_t k, logic [15:0] id, logic [1:0] lvl);
    int gap;
    if (idle_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(19, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, lvl, id, 2'(k)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(serve_request(k, id, lvl));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // let the engine return to idle before any register write
    repeat (2 * 4 * DEPTH + 20) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [7:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_AGE_STEP) step_val = val;
    else thresh_val = val;
  endtask

  // receiver side: random stalls, plus a forced long hold
  always @(posedge clk) begin
    if (long_hold_go && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_cycles <= 400;
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (idle_on && out_tready && $urandom_range(5) == 0) begin
      hold_cycles <= $urandom_range(19, 1);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[1:0], out_tdata[17:2], out_tdata[19:18], out_tdata[26:20]};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got !== want || out_tdata[31:27] !== 5'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d id=%h lvl=%0d prom=%0d got st=%0d id=%h lvl=%0d prom=%0d",
                     want.status, want.served_id, want.served_level, want.promoted_count,
                     got.status, got.served_id, got.served_level, got.promoted_count);
        end
      end
    end
  end

  task automatic test_directed();
    send_request(KIND_DEQ, 16'h0, 2'd0);
    send_request(KIND_ENQ, 16'hFFFF, 2'd3);
    send_request(KIND_ENQ, 16'h0000, 2'd0);
    send_request(KIND_ENQ, 16'hA5A5, 2'd2);
    send_request(KIND_ENQ, 16'h5A5A, 2'd1);
    send_request(KIND_AGE, 16'hFFFF, 2'd3);
    send_request(KIND_AGE, 16'h0, 2'd0);
    send_request(KIND_NOP, 16'hFFFF, 2'd3);
    for (int i = 0; i < 6; i++) send_request(KIND_DEQ, 16'h0, 2'd0);
  endtask

  task automatic test_full_levels();
    // fill level 3 past capacity, then force promotions into a nearly full level 2
    for (int i = 0; i < DEPTH + 2; i++) send_request(KIND_ENQ, 16'(i + 16'h100), 2'd3);
    for (int i = 0; i < DEPTH - 2; i++) send_request(KIND_ENQ, 16'(i + 16'h200), 2'd2);
    send_request(KIND_AGE, 16'h0, 2'd0);
    send_request(KIND_AGE, 16'h0, 2'd0);
    send_request(KIND_AGE, 16'h0, 2'd0);
    while (pending_total() > 0) send_request(KIND_DEQ, 16'h0, 2'd0);
  endtask

  task automatic test_saturation();
    write_register(CFG_AGE_STEP, 8'd255);
    write_register(CFG_AGE_THRESH, 8'd255);
    send_request(KIND_ENQ, 16'h1234, 2'd3);
    send_request(KIND_ENQ, 16'h4321, 2'd2);
    send_request(KIND_AGE, 16'h0, 2'd0);
    send_request(KIND_AGE, 16'h0, 2'd0);
    write_register(CFG_AGE_THRESH, 8'd0);
    write_register(CFG_AGE_STEP, 8'd0);
    send_request(KIND_ENQ, 16'h7777, 2'd3);
    send_request(KIND_AGE, 16'h0, 2'd0);
    while (pending_total() > 0) send_request(KIND_DEQ, 16'h0, 2'd0);
  endtask

  task automatic random_phase(int n, int deq_bias);
    int    r;
    kind_t k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) k = KIND_ENQ;
      else if (r < 45 + deq_bias) k = KIND_DEQ;
      else if (r < 97) k = KIND_AGE;
      else k = KIND_NOP;
      send_request(k, 16'($urandom), 2'($urandom));
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    @(posedge clk);
    long_hold_go = 1'b1;
    for (int i = 0; i < 12; i++) send_request(KIND_ENQ, 16'($urandom), 2'($urandom));
    wait_drained();
  endtask

  task automatic test_random();
    int settings[4][2] = '{'{5, 10}, '{1, 200}, '{40, 60}, '{3, 7}};
    for (int p = 0; p < 4; p++) begin
      write_register(CFG_AGE_STEP, 8'(settings[p][0]));
      write_register(CFG_AGE_THRESH, 8'(settings[p][1]));
      random_phase(350, p == 1 ? 10 : 40);
    end
    idle_on = 1'b0;
    random_phase(250, 40);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_levels();
    test_saturation();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule
